### hdl/nec_pkg.sv
// nec_pkg: shared types, codes and helper functions of the numeric element converter
// used by nec_front, nec_queue, nec_back and numeric_element_converter; no dependencies
package nec_pkg;

    // source format codes
    localparam logic [3:0] FMT_I8  = 4'd0;
    localparam logic [3:0] FMT_U8  = 4'd1;
    localparam logic [3:0] FMT_I16 = 4'd2;
    localparam logic [3:0] FMT_U16 = 4'd3;
    localparam logic [3:0] FMT_I32 = 4'd4;
    localparam logic [3:0] FMT_U32 = 4'd5;
    localparam logic [3:0] FMT_I64 = 4'd6;
    localparam logic [3:0] FMT_U64 = 4'd7;
    localparam logic [3:0] FMT_F32 = 4'd8;
    localparam logic [3:0] FMT_F64 = 4'd9;
    localparam logic [3:0] FMT_F16 = 4'd10;

    // target type codes
    localparam logic [2:0] TGT_BOOL = 3'd0;
    localparam logic [2:0] TGT_I8   = 3'd1;
    localparam logic [2:0] TGT_CHAR = 3'd2;
    localparam logic [2:0] TGT_I16  = 3'd3;
    localparam logic [2:0] TGT_I32  = 3'd4;
    localparam logic [2:0] TGT_I64  = 3'd5;
    localparam logic [2:0] TGT_F32  = 3'd6;
    localparam logic [2:0] TGT_F64  = 3'd7;

    // configuration register indexes
    localparam logic [1:0] REG_SOURCE_FORMAT = 2'd0;
    localparam logic [1:0] REG_SWAP_BYTES    = 2'd1;
    localparam logic [1:0] REG_TARGET_TYPE   = 2'd2;

    localparam logic [3:0] RESET_SOURCE_FORMAT = FMT_U8;
    localparam logic [2:0] RESET_TARGET_TYPE   = TGT_I32;

    localparam int QUEUE_DEPTH = 2;

    // classified word handed from front to back
    typedef struct packed {
        logic               direct;   // dval is the final result
        logic [63:0]        dval;
        logic               neg;
        logic [63:0]        m;        // value is m * 2^e
        logic signed [13:0] e;
        logic [2:0]         tgt;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } item_bus_t;

    function automatic logic [3:0] src_bytes(input logic [3:0] fmt);
        logic [3:0] n;
        begin
            case (fmt)
                FMT_I8, FMT_U8:            n = 4'd1;
                FMT_I16, FMT_U16, FMT_F16: n = 4'd2;
                FMT_I32, FMT_U32, FMT_F32: n = 4'd4;
                FMT_I64, FMT_U64, FMT_F64: n = 4'd8;
                default:                   n = 4'd0;
            endcase
            return n;
        end
    endfunction

    // keep the low bytes at the element width, optionally byte reversed
    function automatic logic [63:0] take_bytes(input logic [63:0] v, input logic [3:0] n,
                                               input logic swap);
        logic [63:0] r;
        begin
            case (n)
                4'd1: r = {56'd0, v[7:0]};
                4'd2: r = swap ? {48'd0, v[7:0], v[15:8]} : {48'd0, v[15:0]};
                4'd4: r = swap ? {32'd0, v[7:0], v[15:8], v[23:16], v[31:24]}
                               : {32'd0, v[31:0]};
                4'd8: r = swap ? {v[7:0], v[15:8], v[23:16], v[31:24],
                                  v[39:32], v[47:40], v[55:48], v[63:56]} : v;
                default: r = 64'd0;
            endcase
            return r;
        end
    endfunction

    // exact widening of a half to a single
    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [31:0] sgn;
        logic [4:0]  ex;
        logic [9:0]  fr;
        logic [3:0]  p;
        logic [31:0] sh;
        logic [31:0] r;
        begin
            sgn = {h[15], 31'd0};
            ex  = h[14:10];
            fr  = h[9:0];
            p   = 4'd0;
            for (int i = 0; i < 10; i++)
            begin
                if (fr[i])
                    p = 4'(i);
            end
            sh = {22'd0, fr} << (5'd23 - {1'b0, p});
            if (ex == 5'd0)
            begin
                if (fr == 10'd0)
                    r = sgn;
                else
                    r = sgn | {1'b0, 8'd103 + {4'd0, p}, sh[22:0]};
            end
            else if (ex != 5'd31)
                r = sgn | {1'b0, {3'd0, ex} + 8'd112, fr, 13'd0};
            else if (fr == 10'd0)
                r = sgn | 32'h7f800000;
            else
                r = sgn | 32'h7f800001 | {9'd0, fr[9], 22'd0};
            return r;
        end
    endfunction

    // leading zero count, 64 for a zero word
    function automatic logic [6:0] lzc64(input logic [63:0] v);
        logic [6:0] n;
        begin
            n = 7'd64;
            for (int i = 0; i < 64; i++)
            begin
                if (v[i])
                    n = 7'(63 - i);
            end
            return n;
        end
    endfunction

endpackage

### hdl/numeric_element_converter.sv
// numeric_element_converter: top level, configuration registers and the three parts
// depends on nec_pkg, nec_front, nec_queue, nec_back
//
// Converts one raw buffer word per clock into a target primitive value. A word is
// taken at a rising edge where start is high and busy is low; busy stays low in
// normal streaming since the back end drains the queue every cycle and the
// receiver cannot stall, so one word per clock is sustained. Each result appears
// on result_bits for one cycle with done high, after passing the front register
// (swap, sign extension, half widening, unpacking), which loads at the start edge,
// the queue and the back stages (leading zero count, normalize, align with sticky,
// round or saturate). Results leave in input order. Configuration must be written
// through cfg_we / cfg_index / cfg_data only while no word is in flight; the block
// itself does not enforce this.
module numeric_element_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] raw_element,
    output logic        done,
    output logic [63:0] result_bits,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    // configuration registers
    logic [3:0] source_format_reg, source_format_next;
    logic       swap_bytes_reg, swap_bytes_next;
    logic [2:0] target_type_reg, target_type_next;

    always_comb
    begin
        source_format_next = source_format_reg;
        swap_bytes_next    = swap_bytes_reg;
        target_type_next   = target_type_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                nec_pkg::REG_SOURCE_FORMAT: source_format_next = cfg_data;
                nec_pkg::REG_SWAP_BYTES:    swap_bytes_next    = cfg_data[0];
                nec_pkg::REG_TARGET_TYPE:   target_type_next   = cfg_data[2:0];
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_format_reg <= nec_pkg::RESET_SOURCE_FORMAT;
            swap_bytes_reg    <= 1'b0;
            target_type_reg   <= nec_pkg::RESET_TARGET_TYPE;
        end
        else
        begin
            source_format_reg <= source_format_next;
            swap_bytes_reg    <= swap_bytes_next;
            target_type_reg   <= target_type_next;
        end
    end

    nec_pkg::item_bus_t front_bus, back_bus;
    logic               q_full;
    logic               load;

    // front word holds while the queue is full
    assign busy = front_bus.valid && q_full;
    assign load = start && !busy;

    nec_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .advance     (!q_full),
        .raw_element (raw_element),
        .fmt         (source_format_reg),
        .swap        (swap_bytes_reg),
        .tgt         (target_type_reg),
        .out_bus     (front_bus)
    );

    nec_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_bus  (front_bus),
        .full    (q_full),
        .out_bus (back_bus)
    );

    nec_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_bus      (back_bus),
        .done        (done),
        .result_bits (result_bits)
    );

endmodule

### hdl/nec_front.sv
// nec_front: byte order, sign extension, half widening and float unpacking
// depends on nec_pkg
module nec_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              advance,
    input  logic [63:0]       raw_element,
    input  logic [3:0]        fmt,
    input  logic              swap,
    input  logic [2:0]        tgt,
    output nec_pkg::item_bus_t out_bus
);

    logic              valid_reg, valid_next;
    nec_pkg::item_t    item_reg, item_next;

    logic [3:0]  nb;
    logic [63:0] v, sv, mag, bits64;
    logic        is_int, sgn, ineg, is32, is_nan, is_inf, is_zero, fneg;
    logic [31:0] b32;
    logic [10:0] ef;
    logic [51:0] frac;

    always_comb
    begin
        nb     = nec_pkg::src_bytes(fmt);
        v      = nec_pkg::take_bytes(raw_element, nb, swap);
        is_int = (fmt < nec_pkg::FMT_F32);
        sgn    = ~fmt[0];
        case (nb)
            4'd1:    ineg = sgn & v[7];
            4'd2:    ineg = sgn & v[15];
            4'd4:    ineg = sgn & v[31];
            default: ineg = sgn & v[63];
        endcase
        case (nb)
            4'd1:    sv = ineg ? {56'hffffffffffffff, v[7:0]} : v;
            4'd2:    sv = ineg ? {48'hffffffffffff, v[15:0]} : v;
            4'd4:    sv = ineg ? {32'hffffffff, v[31:0]} : v;
            default: sv = v;
        endcase
        mag  = ineg ? (64'd0 - sv) : sv;

        is32 = (fmt != nec_pkg::FMT_F64);
        b32  = (fmt == nec_pkg::FMT_F16) ? nec_pkg::half_to_single(v[15:0]) : v[31:0];
        bits64 = is32 ? {32'd0, b32} : v;
        if (is32)
        begin
            ef   = {3'd0, b32[30:23]};
            frac = {29'd0, b32[22:0]};
            fneg = b32[31];
            is_nan = (b32[30:23] == 8'hff) && (b32[22:0] != 23'd0);
            is_inf = (b32[30:23] == 8'hff) && (b32[22:0] == 23'd0);
        end
        else
        begin
            ef   = v[62:52];
            frac = v[51:0];
            fneg = v[63];
            is_nan = (ef == 11'h7ff) && (frac != 52'd0);
            is_inf = (ef == 11'h7ff) && (frac == 52'd0);
        end
        is_zero = (ef == 11'd0) && (frac == 52'd0);

        item_next      = item_reg;
        item_next.tgt  = tgt;
        item_next.direct = 1'b0;
        item_next.dval = 64'd0;
        item_next.neg  = is_int ? ineg : fneg;
        item_next.m    = mag;
        item_next.e    = 14'sd0;
        if (!is_int)
        begin
            if (is32)
            begin
                item_next.m = (ef == 11'd0) ? {12'd0, frac} : {41'd1, frac[22:0]};
                item_next.e = (ef == 11'd0) ? -14'sd149 : $signed({3'd0, ef}) - 14'sd150;
            end
            else
            begin
                item_next.m = (ef == 11'd0) ? {12'd0, frac} : {12'd1, frac};
                item_next.e = (ef == 11'd0) ? -14'sd1074 : $signed({3'd0, ef}) - 14'sd1075;
            end
            if (is_inf)
            begin
                item_next.m = {64{1'b1}};
                item_next.e = 14'sd0;
            end
        end

        if (nb == 4'd0)
        begin
            item_next.direct = 1'b1;
        end
        else if (is_int)
        begin
            item_next.direct = 1'b1;
            case (tgt)
                nec_pkg::TGT_BOOL: item_next.dval = {63'd0, sv != 64'd0};
                nec_pkg::TGT_I8:   item_next.dval = {56'd0, sv[7:0]};
                nec_pkg::TGT_CHAR,
                nec_pkg::TGT_I16:  item_next.dval = {48'd0, sv[15:0]};
                nec_pkg::TGT_I32:  item_next.dval = {32'd0, sv[31:0]};
                nec_pkg::TGT_I64:  item_next.dval = sv;
                default:           item_next.direct = 1'b0;
            endcase
        end
        else
        begin
            case (tgt)
                nec_pkg::TGT_BOOL:
                begin
                    item_next.direct = 1'b1;
                    item_next.dval   = {63'd0, !is_zero};
                end
                nec_pkg::TGT_F32:
                begin
                    if (is32)
                    begin
                        item_next.direct = 1'b1;
                        item_next.dval   = bits64;
                    end
                    else if (is_nan)
                    begin
                        item_next.direct = 1'b1;
                        item_next.dval   = {32'd0, fneg, 31'h7fc00000 | {8'd0, frac[51:29]}};
                    end
                    else if (is_inf)
                    begin
                        item_next.direct = 1'b1;
                        item_next.dval   = {32'd0, fneg, 31'h7f800000};
                    end
                end
                nec_pkg::TGT_F64:
                begin
                    if (!is32)
                    begin
                        item_next.direct = 1'b1;
                        item_next.dval   = bits64;
                    end
                    else if (is_nan)
                    begin
                        item_next.direct = 1'b1;
                        item_next.dval   = {fneg, 63'h7ff8000000000000 | {11'd0, frac[22:0], 29'd0}};
                    end
                    else if (is_inf)
                    begin
                        item_next.direct = 1'b1;
                        item_next.dval   = {fneg, 63'h7ff0000000000000};
                    end
                end
                default:
                begin
                    // integer targets: nan and zero give 0
                    if (is_nan || is_zero)
                    begin
                        item_next.direct = 1'b1;
                        item_next.dval   = 64'd0;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
            valid_next = 1'b0;
        if (load)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= item_next;
    end

    assign out_bus.valid = valid_reg;
    assign out_bus.item  = item_reg;

endmodule

### hdl/nec_queue.sv
// nec_queue: short fifo of classified words between front and back
// depends on nec_pkg
module nec_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  nec_pkg::item_bus_t in_bus,
    output logic               full,
    output nec_pkg::item_bus_t out_bus
);

    localparam int PW = $clog2(nec_pkg::QUEUE_DEPTH);

    nec_pkg::item_t          mem_reg [nec_pkg::QUEUE_DEPTH];
    logic [PW-1:0]           wr_reg, wr_next, rd_reg, rd_next;
    logic [PW:0]             cnt_reg, cnt_next;
    logic                    push, pop;

    // back end never stalls: pop whenever a word is held
    assign pop  = (cnt_reg != '0);
    assign full = (cnt_reg == (PW+1)'(nec_pkg::QUEUE_DEPTH));
    assign push = in_bus.valid && !full;

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= in_bus.item;
    end

    assign out_bus.valid = pop;
    assign out_bus.item  = mem_reg[rd_reg];

endmodule

### hdl/nec_back.sv
// nec_back: four stage normalize, align, round and saturate pipeline
// depends on nec_pkg
module nec_back (
    input  logic               clk,
    input  logic               rst_n,
    input  nec_pkg::item_bus_t in_bus,
    output logic               done,
    output logic [63:0]        result_bits
);

    typedef struct packed {
        logic               direct;
        logic [63:0]        dval;
        logic               neg;
        logic [63:0]        m;
        logic signed [13:0] e;
        logic [2:0]         tgt;
        logic [6:0]         lz;
    } s1_t;

    typedef struct packed {
        logic               direct;
        logic [63:0]        dval;
        logic               neg;
        logic               zero;
        logic [63:0]        nm;
        logic signed [13:0] big_e;
        logic [2:0]         tgt;
    } s2_t;

    typedef struct packed {
        logic               direct;
        logic [63:0]        dval;
        logic               neg;
        logic               zero;
        logic               ovf;      // float overflow or integer saturation
        logic               under;    // integer magnitude below one
        logic [11:0]        biased;
        logic [63:0]        mant;
        logic               guard;
        logic               sticky;
        logic [2:0]         tgt;
    } s3_t;

    logic [3:0]  v_reg, v_next;
    s1_t         s1_reg, s1_next;
    s2_t         s2_reg, s2_next;
    s3_t         s3_reg, s3_next;
    logic [63:0] res_reg, res_next;

    // stage 1: leading zero count
    always_comb
    begin
        s1_next.direct = in_bus.item.direct;
        s1_next.dval   = in_bus.item.dval;
        s1_next.neg    = in_bus.item.neg;
        s1_next.m      = in_bus.item.m;
        s1_next.e      = in_bus.item.e;
        s1_next.tgt    = in_bus.item.tgt;
        s1_next.lz     = nec_pkg::lzc64(in_bus.item.m);
    end

    // stage 2: normalize so the leading one sits at bit 63
    always_comb
    begin
        s2_next.direct = s1_reg.direct;
        s2_next.dval   = s1_reg.dval;
        s2_next.neg    = s1_reg.neg;
        s2_next.tgt    = s1_reg.tgt;
        s2_next.zero   = s1_reg.lz[6];
        s2_next.nm     = s1_reg.m << s1_reg.lz[5:0];
        s2_next.big_e  = s1_reg.e + 14'sd63 - $signed({7'd0, s1_reg.lz});
    end

    // stage 3: pick the alignment shift and shift right with sticky
    logic signed [13:0] emin, bias_s, extra;
    logic [13:0]        sh_w;
    logic [6:0]         sh;
    logic [127:0]       wide;
    logic [5:0]         fb;

    always_comb
    begin
        fb     = (s2_reg.tgt == nec_pkg::TGT_F32) ? 6'd23 : 6'd52;
        bias_s = (s2_reg.tgt == nec_pkg::TGT_F32) ? 14'sd127 : 14'sd1023;
        emin   = 14'sd1 - bias_s;
        extra  = (s2_reg.big_e < emin) ? (emin - s2_reg.big_e) : 14'sd0;
        s3_next.direct = s2_reg.direct;
        s3_next.dval   = s2_reg.dval;
        s3_next.neg    = s2_reg.neg;
        s3_next.zero   = s2_reg.zero;
        s3_next.tgt    = s2_reg.tgt;
        s3_next.under  = 1'b0;
        s3_next.biased = '0;
        if (s2_reg.tgt == nec_pkg::TGT_F32 || s2_reg.tgt == nec_pkg::TGT_F64)
        begin
            s3_next.ovf    = (s2_reg.big_e > bias_s);
            sh_w           = 14'(14'sd63 - $signed({8'd0, fb}) + extra);
            s3_next.biased = 12'(((s2_reg.big_e < emin) ? emin : s2_reg.big_e) + bias_s);
        end
        else
        begin
            s3_next.ovf   = (s2_reg.big_e > 14'sd63);
            s3_next.under = (s2_reg.big_e < 14'sd0);
            sh_w          = 14'(14'sd63 - s2_reg.big_e);
        end
        sh   = (sh_w > 14'd65) ? 7'd65 : sh_w[6:0];
        wide = {s2_reg.nm, 64'd0} >> sh;
        s3_next.mant   = wide[127:64];
        s3_next.guard  = wide[63];
        s3_next.sticky = |wide[62:0];
    end

    // stage 4: round and pack, or saturate to the integer range
    logic [5:0]  fb4;
    logic [11:0] emax, bexp;
    logic [63:0] mr, fmask, mag, lim, wmask, clip, sbit;
    logic        sgnd;

    always_comb
    begin
        fb4   = (s3_reg.tgt == nec_pkg::TGT_F32) ? 6'd23 : 6'd52;
        emax  = (s3_reg.tgt == nec_pkg::TGT_F32) ? 12'd255 : 12'd2047;
        sbit  = {63'd0, s3_reg.neg} << ({1'b0, fb4} + ((s3_reg.tgt == nec_pkg::TGT_F32)
                                                       ? 7'd8 : 7'd11));
        fmask = (64'd1 << fb4) - 64'd1;
        mr    = s3_reg.mant + {63'd0, s3_reg.guard & (s3_reg.sticky | s3_reg.mant[0])};
        bexp  = s3_reg.biased;
        if ((mr >> ({1'b0, fb4} + 7'd1)) != 64'd0)
        begin
            mr   = mr >> 1;
            bexp = bexp + 12'd1;
        end

        mag = s3_reg.ovf ? {64{1'b1}} : (s3_reg.under ? 64'd0 : s3_reg.mant);
        case (s3_reg.tgt)
            nec_pkg::TGT_I8:   wmask = 64'hff;
            nec_pkg::TGT_CHAR,
            nec_pkg::TGT_I16:  wmask = 64'hffff;
            nec_pkg::TGT_I32:  wmask = 64'hffffffff;
            default:           wmask = {64{1'b1}};
        endcase
        sgnd = (s3_reg.tgt != nec_pkg::TGT_CHAR);
        lim  = (wmask >> 1) + 64'd1;
        if (sgnd)
        begin
            clip = (mag >= lim) ? lim : mag;
            if (!s3_reg.neg && mag >= lim)
                clip = lim - 64'd1;
        end
        else
            clip = (mag > wmask) ? wmask : mag;

        case (s3_reg.tgt)
            nec_pkg::TGT_F32,
            nec_pkg::TGT_F64:
            begin
                if (s3_reg.zero)
                    res_next = sbit;
                else if (s3_reg.ovf)
                    res_next = sbit | ({52'd0, emax} << fb4);
                else if (mr < (64'd1 << fb4))
                    res_next = sbit | mr;
                else if (bexp >= emax)
                    res_next = sbit | ({52'd0, emax} << fb4);
                else
                    res_next = sbit | ({52'd0, bexp} << fb4) | (mr & fmask);
            end
            default:
            begin
                if (s3_reg.neg)
                    res_next = sgnd ? ((64'd0 - clip) & wmask) : 64'd0;
                else
                    res_next = clip;
            end
        endcase
        if (s3_reg.direct)
            res_next = s3_reg.dval;
    end

    assign v_next = {v_reg[2:0], in_bus.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    always_ff @(posedge clk)
    begin
        s1_reg  <= s1_next;
        s2_reg  <= s2_next;
        s3_reg  <= s3_next;
        res_reg <= res_next;
    end

    assign done        = v_reg[3];
    assign result_bits = res_reg;

endmodule

### tb/numeric_element_converter_test.sv
`timescale 1ns / 1ps
// numeric_element_converter_test: self-checking testbench of the numeric element converter
// depends on nec_pkg and numeric_element_converter; holds its own conversion predictor
module numeric_element_converter_test;
    import nec_pkg::*;

    // value classes of an unpacked float
    typedef enum logic [1:0] {FC_ZERO, FC_FIN, FC_INF, FC_NAN} fclass_t;

    // unpacked float: value is m * 2^e
    typedef struct {
        fclass_t     cls;
        logic        neg;
        logic [63:0] m;
        int          e;
        logic [63:0] frac;
    } unpacked_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [63:0] raw_element = 64'd0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [3:0]  cfg_data = 4'd0;
    logic        busy;
    logic        done;
    logic [63:0] result_bits;

    // predictor copy of the registers
    logic [3:0]  cur_format = RESET_SOURCE_FORMAT;
    logic        cur_swap = 1'b0;
    logic [2:0]  cur_target = RESET_TARGET_TYPE;

    logic [63:0] expected_results[$];
    int          mismatch_count = 0;

    numeric_element_converter i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .raw_element (raw_element),
        .done        (done),
        .result_bits (result_bits),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever
            #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [63:0] low_mask(input int w);
        if (w >= 64)
            return '1;
        return (64'd1 << w) - 64'd1;
    endfunction

    function automatic int top_bit(input logic [63:0] v);
        int p;
        p = 0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
                p = i;
        end
        return p;
    endfunction

    function automatic unpacked_t unpack_ieee(input logic [63:0] bits, input int ebits,
                                              input int fbits);
        unpacked_t   u;
        int          bias;
        logic [63:0] emask;
        logic [63:0] ef;
        bias   = (1 << (ebits - 1)) - 1;
        emask  = low_mask(ebits);
        ef     = (bits >> fbits) & emask;
        u.frac = bits & low_mask(fbits);
        u.neg  = bits[ebits + fbits];
        u.m    = 64'd0;
        u.e    = 0;
        if (ef == emask)
            u.cls = (u.frac != 0) ? FC_NAN : FC_INF;
        else if (ef == 0)
        begin
            u.cls = (u.frac != 0) ? FC_FIN : FC_ZERO;
            u.m   = u.frac;
            u.e   = 1 - bias - fbits;
        end
        else
        begin
            u.cls = FC_FIN;
            u.m   = u.frac | (64'd1 << fbits);
            u.e   = int'(ef) - bias - fbits;
        end
        return u;
    endfunction

    // round m * 2^e to nearest even, overflow to infinity, gradual underflow
    function automatic logic [63:0] round_to_ieee(input logic neg, input logic [63:0] m,
                                                  input int e, input int ebits,
                                                  input int fbits);
        logic [63:0] sbit;
        logic [63:0] emax;
        logic [63:0] mant;
        logic [63:0] rem;
        logic [63:0] half;
        int          bias;
        int          big_e;
        int          q;
        int          s;
        int          biased;
        sbit = {63'd0, neg} << (ebits + fbits);
        bias = (1 << (ebits - 1)) - 1;
        emax = low_mask(ebits);
        if (m == 0)
            return sbit;
        big_e = top_bit(m) + e;
        if (big_e > bias)
            return sbit | (emax << fbits);
        q = ((big_e > 1 - bias) ? big_e : 1 - bias) - fbits;
        s = q - e;
        if (s <= 0)
            mant = m << (-s);
        else if (s > 64)
            mant = 64'd0;
        else if (s == 64)
            mant = (m > 64'h8000_0000_0000_0000) ? 64'd1 : 64'd0;
        else
        begin
            rem  = m & low_mask(s);
            half = 64'd1 << (s - 1);
            mant = m >> s;
            if (rem > half || (rem == half && mant[0]))
                mant = mant + 64'd1;
        end
        if ((mant >> (fbits + 1)) != 0)
        begin
            mant = mant >> 1;
            q++;
        end
        if (mant < (64'd1 << fbits))
            return sbit | mant;
        biased = q + fbits + bias;
        if (64'(biased) >= emax)
            return sbit | (emax << fbits);
        return sbit | (64'(biased) << fbits) | (mant & low_mask(fbits));
    endfunction

    // truncate toward zero and saturate, nan gives zero
    function automatic logic [63:0] float_to_integer(input unpacked_t u, input int w,
                                                     input logic sgn);
        logic [63:0] mag;
        logic [63:0] lim;
        if (u.cls == FC_NAN || u.cls == FC_ZERO)
            return 64'd0;
        if (u.cls == FC_INF)
            mag = '1;
        else if (u.e >= 0)
        begin
            if (u.e >= 64 || u.m > (64'hffff_ffff_ffff_ffff >> u.e))
                mag = '1;
            else
                mag = u.m << u.e;
        end
        else
            mag = (-u.e >= 64) ? 64'd0 : (u.m >> (-u.e));
        if (sgn)
        begin
            lim = 64'd1 << (w - 1);
            if (u.neg)
                return (64'd0 - ((mag >= lim) ? lim : mag)) & low_mask(w);
            return ((mag >= lim) ? lim - 64'd1 : mag) & low_mask(w);
        end
        if (u.neg)
            return 64'd0;
        return (mag > low_mask(w)) ? low_mask(w) : mag;
    endfunction

    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [31:0] sign;
        logic [31:0] ex;
        logic [31:0] fr;
        int          p;
        sign = {h[15], 31'd0};
        ex   = {27'd0, h[14:10]};
        fr   = {22'd0, h[9:0]};
        if (ex == 0)
        begin
            if (fr == 0)
                return sign;
            p = top_bit({32'd0, fr});
            return sign | (32'(127 - 24 + p) << 23) | ((fr << (23 - p)) & 32'h007f_ffff);
        end
        if (ex < 31)
            return sign | ((ex - 32'd15 + 32'd127) << 23) | (fr << 13);
        if (fr == 0)
            return sign | 32'h7f80_0000;
        return sign | 32'h7f80_0001 | ((fr & 32'h200) << 13);
    endfunction

    function automatic logic [63:0] from_float(input logic [63:0] bits, input logic is32);
        unpacked_t   u;
        logic [63:0] sb;
        u  = is32 ? unpack_ieee(bits, 8, 23) : unpack_ieee(bits, 11, 52);
        sb = {63'd0, u.neg};
        case (cur_target)
            TGT_BOOL: return (u.cls != FC_ZERO) ? 64'd1 : 64'd0;
            TGT_I8:   return float_to_integer(u, 8, 1'b1);
            TGT_CHAR: return float_to_integer(u, 16, 1'b0);
            TGT_I16:  return float_to_integer(u, 16, 1'b1);
            TGT_I32:  return float_to_integer(u, 32, 1'b1);
            TGT_I64:  return float_to_integer(u, 64, 1'b1);
            TGT_F32:
            begin
                if (is32)
                    return bits;
                if (u.cls == FC_NAN)
                    return (sb << 31) | 64'h7fc0_0000 | (u.frac >> 29);
                if (u.cls == FC_INF)
                    return (sb << 31) | 64'h7f80_0000;
                return round_to_ieee(u.neg, u.m, u.e, 8, 23);
            end
            default:
            begin
                if (!is32)
                    return bits;
                if (u.cls == FC_NAN)
                    return (sb << 63) | 64'h7ff8_0000_0000_0000 | (u.frac << 29);
                if (u.cls == FC_INF)
                    return (sb << 63) | 64'h7ff0_0000_0000_0000;
                return round_to_ieee(u.neg, u.m, u.e, 11, 52);
            end
        endcase
    endfunction

    function automatic logic [63:0] from_integer(input logic [63:0] v, input int nbytes,
                                                 input logic sgn);
        logic [63:0] sv;
        logic [63:0] mag;
        logic        neg;
        int          nbits;
        nbits = nbytes * 8;
        sv    = v;
        neg   = 1'b0;
        if (sgn && v[nbits - 1])
        begin
            sv  = v | ~low_mask(nbits);
            neg = 1'b1;
        end
        mag = neg ? 64'd0 - sv : sv;
        case (cur_target)
            TGT_BOOL: return (sv != 0) ? 64'd1 : 64'd0;
            TGT_I8:   return sv & 64'hff;
            TGT_CHAR: return sv & 64'hffff;
            TGT_I16:  return sv & 64'hffff;
            TGT_I32:  return sv & 64'hffff_ffff;
            TGT_I64:  return sv;
            TGT_F32:  return round_to_ieee(neg, mag, 0, 8, 23);
            default:  return round_to_ieee(neg, mag, 0, 11, 52);
        endcase
    endfunction

    function automatic logic [63:0] convert_element(input logic [63:0] raw);
        int          nbytes;
        logic [63:0] v;
        logic [63:0] w;
        case (cur_format)
            FMT_I8, FMT_U8:            nbytes = 1;
            FMT_I16, FMT_U16, FMT_F16: nbytes = 2;
            FMT_I32, FMT_U32, FMT_F32: nbytes = 4;
            FMT_I64, FMT_U64, FMT_F64: nbytes = 8;
            default:                   nbytes = 0;
        endcase
        if (nbytes == 0)
            return 64'd0;
        v = raw & low_mask(nbytes * 8);
        if (cur_swap)
        begin
            w = 64'd0;
            for (int i = 0; i < nbytes; i++)
                w = (w << 8) | ((v >> (8 * i)) & 64'hff);
            v = w;
        end
        if (cur_format < FMT_F32)
            return from_integer(v, nbytes, ~cur_format[0]);
        if (cur_format == FMT_F32)
            return from_float(v, 1'b1);
        if (cur_format == FMT_F64)
            return from_float(v, 1'b0);
        return from_float({32'd0, widen_half(v[15:0])}, 1'b1);
    endfunction

    // ---------------------------------------------------------------- drivers

    // one word: held until an edge with busy low, start left high for the next word
    task automatic send_word(input logic [63:0] raw);
        start       <= 1'b1;
        raw_element <= raw;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_results.push_back(convert_element(raw));
    endtask

    task automatic pause_sender(input int cycles);
        start       <= 1'b0;
        raw_element <= {$urandom, $urandom};
        repeat (cycles) @(posedge clk);
    endtask

    // drain every word in flight, then wait out the pipeline
    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [3:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_SOURCE_FORMAT: cur_format = data;
            REG_SWAP_BYTES:    cur_swap = data[0];
            REG_TARGET_TYPE:   cur_target = data[2:0];
            default:           ;
        endcase
    endtask

    task automatic set_mode(input logic [3:0] fmt, input logic swap, input logic [2:0] tgt);
        drain();
        write_reg(REG_SOURCE_FORMAT, fmt);
        write_reg(REG_SWAP_BYTES, {3'd0, swap});
        write_reg(REG_TARGET_TYPE, {1'b0, tgt});
    endtask

    // random element biased toward the interesting corners of its format
    function automatic logic [63:0] pick_element(input logic [3:0] fmt);
        logic [63:0] r;
        logic [63:0] ex;
        int          kind;
        r    = {$urandom, $urandom};
        kind = $urandom_range(0, 5);
        if (kind == 0)
            return r;
        case (fmt)
            FMT_F16:
            begin
                case (kind)
                    1: ex = 64'd0;
                    2: ex = 64'd31;
                    default: ex = $urandom_range(10, 30);
                endcase
                r[14:10] = ex[4:0];
                if (kind == 2 && $urandom_range(0, 1) == 0)
                    r[9:0] = 10'd0;
            end
            FMT_F32:
            begin
                case (kind)
                    1: ex = 64'd0;
                    2: ex = 64'd255;
                    3: ex = $urandom_range(120, 200);
                    default: ex = $urandom_range(0, 255);
                endcase
                r[30:23] = ex[7:0];
                if ($urandom_range(0, 3) == 0)
                    r[22:0] = r[22:0] & ~({23{1'b1}} >> $urandom_range(0, 23));
            end
            FMT_F64:
            begin
                case (kind)
                    1: ex = 64'd0;
                    2: ex = 64'd2047;
                    3: ex = $urandom_range(1000, 1100);
                    4: ex = $urandom_range(870, 1160);
                    default: ex = $urandom_range(0, 2047);
                endcase
                r[62:52] = ex[10:0];
                if ($urandom_range(0, 3) == 0)
                    r[51:0] = r[51:0] & ~({52{1'b1}} >> $urandom_range(0, 52));
            end
            default:
            begin
                // integers: small magnitudes, near zero and near the extremes
                if (kind == 1)
                    r = 64'($urandom_range(0, 3));
                else if (kind == 2)
                    r = ~64'($urandom_range(0, 3));
                else if (kind == 3)
                    r = r >> $urandom_range(0, 63);
            end
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------- checker

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word %h", result_bits);
            end
            else
            begin
                logic [63:0] want;
                want = expected_results.pop_front();
                if (result_bits !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result_bits mismatch: expected %h actual %h",
                                 want, result_bits);
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // reset values, integer widening and narrowing, unknown formats
    task automatic test_integers;
        send_word(64'h0000_0000_0000_00ff);
        send_word(64'hffff_ffff_ffff_ff00);
        set_mode(FMT_I8, 1'b0, TGT_I64);
        send_word(64'h80);
        set_mode(FMT_I64, 1'b0, TGT_F32);
        send_word(64'h8000_0000_0000_0000);
        send_word(64'h0000_0000_0100_0003);
        set_mode(FMT_I64, 1'b1, TGT_F64);
        send_word(64'hffff_ffff_ffff_ff7f);
        set_mode(FMT_U64, 1'b0, TGT_F32);
        send_word(64'hffff_ffff_ffff_ffff);
        set_mode(4'd12, 1'b0, TGT_BOOL);
        send_word(64'h1234_5678_9abc_def0);
        set_mode(4'd15, 1'b1, TGT_F64);
        send_word(64'hffff_ffff_ffff_ffff);
    endtask

    // nan, infinity, saturation, subnormals and half widening
    task automatic test_float_cases;
        set_mode(FMT_F32, 1'b0, TGT_I8);
        send_word(64'h7fc0_0000);
        send_word(64'h7f80_0000);
        send_word(64'hd015_3180);
        set_mode(FMT_F32, 1'b0, TGT_F64);
        send_word(64'h7f80_0001);
        send_word(64'h0000_0001);
        set_mode(FMT_F64, 1'b0, TGT_F32);
        send_word(64'hfff0_0000_0000_0001);
        send_word(64'h0000_0000_0000_0001);
        send_word(64'h47ef_ffff_e000_0000);
        set_mode(FMT_F64, 1'b0, TGT_CHAR);
        send_word(64'hbff8_0000_0000_0000);
        send_word(64'h40f1_1700_0000_0000);
        set_mode(FMT_F16, 1'b1, TGT_F32);
        send_word(64'h0100);
        send_word(64'h017c);
        send_word(64'h00fc);
        set_mode(FMT_F16, 1'b0, TGT_BOOL);
        send_word(64'h8000);
        send_word(64'h7e01);
    endtask

    // random modes, bursts of sender gaps, the last phases streaming back to back
    task automatic test_random_streams;
        logic [3:0] fmt;
        logic [2:0] tgt;
        logic       swap;
        int         gaps;
        for (int phase = 0; phase < 46; phase++)
        begin
            fmt  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(11, 15))
                                               : 4'($urandom_range(0, 10));
            tgt  = 3'($urandom_range(0, 7));
            swap = 1'($urandom_range(0, 1));
            if (phase == 0)
                fmt = 4'd0;
            if (phase == 1)
                fmt = 4'd15;
            set_mode(fmt, swap, tgt);
            gaps = (phase < 40) && ($urandom_range(0, 3) != 0);
            for (int n = 0; n < 25; n++)
            begin
                send_word(pick_element(fmt));
                if (gaps && $urandom_range(0, 3) == 0)
                    pause_sender($urandom_range(1, 5));
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_integers();
        test_float_cases();
        test_random_streams();
        drain();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("numeric_element_converter_test: clean");
        else
            $display("numeric_element_converter_test: errors");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("numeric_element_converter_test: errors");
        $finish;
    end

endmodule

### filelist.f
hdl/nec_pkg.sv
hdl/nec_front.sv
hdl/nec_queue.sv
hdl/nec_back.sv
hdl/numeric_element_converter.sv
tb/numeric_element_converter_test.sv
